@@ rtl/plc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the plus-code encoder.
// No dependencies; imported by every module of the block.
package plc_pkg;

    // Input transaction: one location
    typedef struct packed {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
    } t_loc;

    // Output transaction: one code character
    typedef struct packed {
        logic [6:0] code_char;
        logic       last;
    } t_char;

    // Normalized location handed from the front end to the back end
    typedef struct packed {
        logic [31:0] alat;      // latitude offset to [0, 180] degrees
        logic [31:0] alon;      // longitude offset to [0, 360) degrees
        logic [2:0]  pairs;     // number of pair digits, 1..5
        logic [3:0]  last_pos;  // index of the final character
    } t_job;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Configuration
    localparam logic [3:0] LENGTH_RST = 4'd10;
    localparam logic [3:0] LEN_MIN    = 4'd2;
    localparam logic [3:0] PAIR_LEN   = 4'd10;
    localparam logic [3:0] GRID_MAX   = 4'd4;

    // Character positions inside one code
    localparam logic [3:0] SEP_POS  = 4'd8;
    localparam logic [3:0] GRID_POS = 4'd11;

    // Range limits in 1e-7 degree
    localparam logic signed [32:0] LAT_LIMIT  = 33'sd900000000;
    localparam logic signed [33:0] LON_LIMIT  = 34'sd1800000000;
    localparam logic signed [33:0] LON_WRAP   = 34'sd5400000000;
    localparam logic [31:0]        LAT_SPAN   = 32'd1800000000;

    // ASCII characters
    localparam logic [6:0] CHAR_PAD = 7'h30;  // '0'
    localparam logic [6:0] CHAR_SEP = 7'h2B;  // '+'

    // Pair-digit cell sizes and exact reciprocals: floor(x / RES) equals
    // (x * RECIP) >> SHIFT for every 32-bit x, RECIP = ceil(2^SHIFT / RES).
    localparam logic [63:0] RES_0 = 64'd200000000;
    localparam logic [63:0] RES_1 = 64'd10000000;
    localparam logic [63:0] RES_2 = 64'd500000;
    localparam logic [63:0] RES_3 = 64'd25000;
    localparam logic [63:0] RES_4 = 64'd1250;
    localparam int unsigned SHIFT_0 = 60;
    localparam int unsigned SHIFT_1 = 56;
    localparam int unsigned SHIFT_2 = 51;
    localparam int unsigned SHIFT_3 = 47;
    localparam int unsigned SHIFT_4 = 43;
    localparam logic [32:0] RECIP_0 = 33'(((64'd1 << SHIFT_0) + RES_0 - 64'd1) / RES_0);
    localparam logic [32:0] RECIP_1 = 33'(((64'd1 << SHIFT_1) + RES_1 - 64'd1) / RES_1);
    localparam logic [32:0] RECIP_2 = 33'(((64'd1 << SHIFT_2) + RES_2 - 64'd1) / RES_2);
    localparam logic [32:0] RECIP_3 = 33'(((64'd1 << SHIFT_3) + RES_3 - 64'd1) / RES_3);
    localparam logic [32:0] RECIP_4 = 33'(((64'd1 << SHIFT_4) + RES_4 - 64'd1) / RES_4);
    localparam logic [10:0] CELL    = 11'd1250;

    // Grid refinement step sizes per grid digit
    localparam logic [10:0] LAT_STEP [4] = '{11'd250, 11'd50, 11'd10, 11'd2};
    localparam logic [10:0] LON_STEP [4] = '{11'd312, 11'd78, 11'd19, 11'd4};

    localparam logic [6:0] DIGIT_SET [20] = '{
        7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,  // 2..9
        7'h43, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4D, 7'h50, 7'h51,  // C F G H J M P Q
        7'h52, 7'h56, 7'h57, 7'h58                               // R V W X
    };

    // Alphabet character of a base-20 digit
    function automatic logic [6:0] digit_char(input logic [4:0] d);
        logic [6:0] c;
        c = CHAR_PAD;
        if (d < 5'd20) begin
            c = DIGIT_SET[d];
        end
        return c;
    endfunction

    // Half the code precision for a length, in 1e-7 degree
    function automatic logic [26:0] half_prec(input logic [3:0] len);
        logic [26:0] hp;
        unique case (len)
            4'd0, 4'd1, 4'd2, 4'd3: hp = 27'd100000000;
            4'd4, 4'd5:             hp = 27'd5000000;
            4'd6, 4'd7:             hp = 27'd250000;
            4'd8, 4'd9:             hp = 27'd12500;
            4'd10:                  hp = 27'd625;
            4'd11:                  hp = 27'd125;
            4'd12:                  hp = 27'd25;
            4'd13:                  hp = 27'd5;
            4'd14:                  hp = 27'd1;
            4'd15:                  hp = 27'd0;
        endcase
        return hp;
    endfunction

endpackage

@@ rtl/plc_front.sv @@
`timescale 1ns / 1ps
// Front end: takes a location transaction, clamps/wraps/offsets it and
// works out the code layout. Depends on plc_pkg.
module plc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  plc_pkg::t_loc  i_loc,
    input  logic [3:0]     i_length,
    input  logic           i_full,
    output logic           o_push,
    output plc_pkg::t_job  o_job
);
    import plc_pkg::*;

    logic               r_valid;
    t_loc               r_loc;
    logic [3:0]         r_len;

    logic               w_take;
    logic [3:0]         w_len;
    logic [3:0]         w_plen;
    logic [3:0]         w_gcnt;
    logic signed [32:0] w_lat;
    logic signed [33:0] w_lon;

    // Holding register: frees up in the cycle its job moves to the queue
    assign o_push = r_valid && !i_full;
    assign o_busy = r_valid && i_full;
    assign w_take = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_loc <= i_loc;
            r_len <= i_length;
        end
    end

    // Length classification, then latitude clamp with pole adjustment,
    // longitude wrap, both offset
    always_comb begin
        w_len  = (r_len < LEN_MIN) ? LEN_MIN : r_len;
        w_plen = (w_len > PAIR_LEN) ? PAIR_LEN : w_len;
        w_gcnt = (w_len > PAIR_LEN) ? (w_len - PAIR_LEN) : 4'd0;
        if (w_gcnt > GRID_MAX) begin
            w_gcnt = GRID_MAX;
        end
        o_job.pairs    = 3'((5'(w_plen) + 5'd1) >> 1);
        o_job.last_pos = (o_job.pairs == 3'd5) ? (PAIR_LEN + w_gcnt) : SEP_POS;

        w_lat = 33'(r_loc.latitude);
        w_lon = 34'(r_loc.longitude);
        priority if (w_lat >= LAT_LIMIT) begin
            o_job.alat = LAT_SPAN - 32'(half_prec(w_len));
        end else if (w_lat < -LAT_LIMIT) begin
            o_job.alat = 32'd0;
        end else begin
            o_job.alat = 32'(w_lat + LAT_LIMIT);
        end
        priority if (w_lon < -LON_LIMIT) begin
            o_job.alon = 32'(w_lon + LON_WRAP);
        end else if (w_lon >= LON_LIMIT) begin
            o_job.alon = 32'(w_lon - LON_LIMIT);
        end else begin
            o_job.alon = 32'(w_lon + LON_LIMIT);
        end
    end

endmodule

@@ rtl/plc_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between front and back end, register based.
// Depends on plc_pkg for the job type.
module plc_queue #(
    parameter int unsigned DEPTH = plc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plc_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output plc_pkg::t_job  o_head
);
    import plc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

@@ rtl/plc_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the character positions of each job, extracts pair and
// grid digits and drives one character per cycle. Depends on plc_pkg.
module plc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  plc_pkg::t_job  i_head,
    output logic           o_pop,
    output logic           o_strobe,
    output plc_pkg::t_char o_result
);
    import plc_pkg::*;

    localparam logic [1:0] KIND_PAIR = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_SEP  = 2'd2;
    localparam logic [1:0] KIND_GRID = 2'd3;
    localparam logic [2:0] K_LAST    = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        coord;   // 0 latitude, 1 longitude
        logic [2:0]  k;       // pair digit level
        logic [1:0]  gidx;    // grid digit index
        logic        last;
        logic [10:0] xlow;    // low bits of the coordinate for the grid remainder
    } t_tag;

    // Issue stage
    logic        r_act;
    logic [3:0]  r_pos;
    t_job        r_job;
    logic        w_last;
    t_tag        w_tag;
    logic [31:0] w_x;
    logic [32:0] w_recip;

    // Digit stage
    logic        r_tv;
    t_tag        r_tag;
    logic [64:0] r_prod;
    logic [2:0]  r_qlat;
    logic [2:0]  r_qlon;
    logic [10:0] r_glat;
    logic [10:0] r_glon;

    logic [10:0] w_q;
    logic [2:0]  w_prev;
    logic [4:0]  w_sub;
    logic [4:0]  w_digit;
    logic [10:0] w_rem;
    logic [10:0] w_lat_step;
    logic [10:0] w_lon_step;
    logic [2:0]  w_row;
    logic [1:0]  w_col;
    logic [10:0] w_glat_next;
    logic [10:0] w_glon_next;
    logic [6:0]  w_char;

    // Job sequencing: next job loads in the cycle the last position issues
    assign w_last = r_act && (r_pos == r_job.last_pos);
    assign o_pop  = i_head_valid && (!r_act || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_pos <= '0;
        end else if (o_pop) begin
            r_act <= 1'b1;
            r_pos <= '0;
        end else if (w_last) begin
            r_act <= 1'b0;
        end else if (r_act) begin
            r_pos <= r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // Classify the current position
    always_comb begin
        w_tag = '0;
        priority if (r_pos < SEP_POS) begin
            if (r_pos < {r_job.pairs, 1'b0}) begin
                w_tag.kind  = KIND_PAIR;
                w_tag.coord = r_pos[0];
                w_tag.k     = {1'b0, r_pos[2:1]};
            end else begin
                w_tag.kind = KIND_PAD;
            end
        end else if (r_pos == SEP_POS) begin
            w_tag.kind = KIND_SEP;
        end else if (r_pos < GRID_POS) begin
            w_tag.kind  = KIND_PAIR;
            w_tag.coord = ~r_pos[0];
            w_tag.k     = K_LAST;
        end else begin
            w_tag.kind = KIND_GRID;
            w_tag.gidx = 2'(r_pos - GRID_POS);
        end
        w_tag.last = w_last;
        w_x        = w_tag.coord ? r_job.alon : r_job.alat;
        w_tag.xlow = w_x[10:0];
        unique case (w_tag.k)
            3'd0:    w_recip = RECIP_0;
            3'd1:    w_recip = RECIP_1;
            3'd2:    w_recip = RECIP_2;
            3'd3:    w_recip = RECIP_3;
            default: w_recip = RECIP_4;
        endcase
    end

    // Reciprocal product, registered before digit extraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= w_tag;
        r_prod <= 65'(w_x) * 65'(w_recip);
    end

    // Pair digit: d = Q mod 20 = Q - 20 * Q_prev, taken modulo 32
    always_comb begin
        unique case (r_tag.k)
            3'd0:    w_q = 11'(r_prod >> SHIFT_0);
            3'd1:    w_q = 11'(r_prod >> SHIFT_1);
            3'd2:    w_q = 11'(r_prod >> SHIFT_2);
            3'd3:    w_q = 11'(r_prod >> SHIFT_3);
            default: w_q = 11'(r_prod >> SHIFT_4);
        endcase
        w_prev  = r_tag.coord ? r_qlon : r_qlat;
        w_sub   = (r_tag.k == 3'd0) ? 5'd0 : 5'(8'(w_prev) * 8'd20);
        w_digit = w_q[4:0] - w_sub;
        // coordinate mod 1250, exact in 11 bits
        w_rem   = r_tag.xlow - 11'(22'(w_q) * 22'(CELL));
    end

    // Grid digit: row and column by comparing against step multiples
    always_comb begin
        w_lat_step = LAT_STEP[r_tag.gidx];
        w_lon_step = LON_STEP[r_tag.gidx];
        w_row = 3'd0;
        w_col = 2'd0;
        for (int j = 1; j <= 4; j++) begin
            if (r_glat >= 11'(14'(j) * 14'(w_lat_step))) begin
                w_row = w_row + 3'd1;
            end
        end
        for (int j = 1; j <= 3; j++) begin
            if (r_glon >= 11'(14'(j) * 14'(w_lon_step))) begin
                w_col = w_col + 2'd1;
            end
        end
        w_glat_next = r_glat - 11'(14'(w_row) * 14'(w_lat_step));
        w_glon_next = r_glon - 11'(14'(w_col) * 14'(w_lon_step));
    end

    // Character select
    always_comb begin
        unique case (r_tag.kind)
            KIND_PAIR: w_char = digit_char(w_digit);
            KIND_PAD:  w_char = CHAR_PAD;
            KIND_SEP:  w_char = CHAR_SEP;
            default:   w_char = digit_char({w_row, w_col});
        endcase
    end

    // Digit history and grid remainders
    always_ff @(posedge i_clk) begin
        if (r_tv) begin
            if (r_tag.kind == KIND_PAIR) begin
                if (r_tag.coord) begin
                    r_qlon <= w_q[2:0];
                end else begin
                    r_qlat <= w_q[2:0];
                end
                if (r_tag.k == K_LAST) begin
                    if (r_tag.coord) begin
                        r_glon <= w_rem;
                    end else begin
                        r_glat <= w_rem;
                    end
                end
            end else if (r_tag.kind == KIND_GRID) begin
                r_glat <= w_glat_next;
                r_glon <= w_glon_next;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.code_char <= w_char;
        o_result.last      <= r_tag.last;
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_pos <= r_job.last_pos))
        else $error("position ran past the last character");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tv && r_tag.kind == KIND_PAIR) |-> (w_digit < 5'd20))
        else $error("pair digit out of base-20 range");

    a_grid_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tv && r_tag.kind == KIND_GRID) |-> (r_glat < CELL && r_glon < CELL))
        else $error("grid remainder outside the cell");

endmodule

@@ rtl/plus_code_location_encoder.sv @@
`timescale 1ns / 1ps
// Plus-code encoder top level: config register, front end, queue, back end.
// Depends on plc_pkg, plc_front, plc_queue and plc_back.
//
// Usage:
//   Input channel: drive i_loc (latitude, longitude in 1e-7 degree) and
//   raise start; the transaction is taken at a clock edge with start high
//   and busy low.
//   Output channel: each code character appears on o_result for one cycle
//   with o_strobe high; o_result.last marks the final character. The
//   receiver cannot stall, so characters leave at one per cycle.
//   Config: i_cfg_we writes i_cfg_data into the code length register
//   (reset value 10); write it only while no location is in flight.
//   Path: holding register, queue, issue stage, digit stage, output register.
//   Throughput: a location occupies the character sequencer for its
//   whole code: 9 characters for lengths up to 8, 11 for 9 and 10, 12 to
//   15 for longer codes. Locations follow each other with no gap; the
//   sequencer's one-character-per-cycle walk sets the rate, and a short
//   job queue plus a holding register absorb the difference in front.
//   Reset: synchronous, active low; clears the holding register, the queue,
//   the sequencer and the strobe, and returns the code length to 10.
module plus_code_location_encoder #(
    parameter int unsigned QUEUE_DEPTH = plc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  plc_pkg::t_loc  i_loc,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data,
    output logic           o_strobe,
    output plc_pkg::t_char o_result
);
    import plc_pkg::*;

    logic [3:0] r_length;
    logic       w_push;
    t_job       w_job;
    logic       w_full;
    logic       w_head_valid;
    t_job       w_head;
    logic       w_pop;

    // Code length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LENGTH_RST;
        end else if (i_cfg_we) begin
            r_length <= i_cfg_data;
        end
    end

    plc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_loc      (i_loc),
        .i_length   (r_length),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    plc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    plc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

endmodule
